/* hdl/imma_pkg.sv */
package imma_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_W           = 64;
  localparam int TS_W            = 63;
  localparam int DEADLINE_W      = 64;
  localparam int INTERVAL_W      = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATH     = 2'd2;

  typedef enum logic [1:0] {
    KIND_MIN = 2'd0,
    KIND_MAX = 2'd1,
    KIND_AVG = 2'd2,
    KIND_CUR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_ALL = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2,
    MODE_AVG = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic signed [63:0] sample_value;
    logic [TS_W-1:0]    timestamp;
  } sample_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] result_value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic  accept;
    logic  div_step;
    logic  load;
    kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic  hit;
    logic  skip;
    mode_t mode;
    logic  path;
    logic  div_last;
  } dp_status_t;

endpackage

/* hdl/imma_dp.sv */
module imma_dp import imma_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sample_t               sample_word,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output result_t               result_word
);

  localparam int DIV_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [VALUE_WIDTH-1:0] MIN_INIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] MAX_INIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // configuration
  mode_t                 report_mode;
  logic [INTERVAL_W-1:0] interval_ticks;
  logic                  path_present;

  // statistics
  logic [VALUE_WIDTH-1:0] current_value;
  logic [VALUE_WIDTH-1:0] running_min;
  logic [VALUE_WIDTH-1:0] running_max;
  logic [VALUE_WIDTH-1:0] running_sum;
  logic [COUNT_WIDTH-1:0] sample_count;
  logic [DEADLINE_W-1:0]  next_deadline;

  // report snapshot and divider
  logic [VALUE_WIDTH-1:0] rep_min;
  logic [VALUE_WIDTH-1:0] rep_max;
  logic                   rep_neg;
  logic [COUNT_WIDTH-1:0] rep_count;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [COUNT_WIDTH-1:0] div_rem;
  logic [DIV_CNT_W-1:0]   div_cnt;

  logic [VALUE_WIDTH-1:0] sample_v;
  logic [VALUE_WIDTH-1:0] new_v;
  logic [VALUE_WIDTH-1:0] min_new;
  logic [VALUE_WIDTH-1:0] max_new;
  logic [VALUE_WIDTH-1:0] sum_new;
  logic [VALUE_WIDTH-1:0] sum_mag;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   hit;
  logic                   skip;
  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH:0]   rem_diff;
  logic                   rem_ge;
  logic [VALUE_WIDTH-1:0] avg;
  logic [VALUE_WIDTH-1:0] out_v;

  assign sample_v = sample_word.sample_value[VALUE_WIDTH-1:0];
  assign new_v    = sample_word.cmd ? (current_value + sample_v) : sample_v;
  assign min_new  = ($signed(new_v) < $signed(running_min)) ? new_v : running_min;
  assign max_new  = ($signed(running_max) < $signed(new_v)) ? new_v : running_max;
  assign sum_new  = running_sum + new_v;
  assign sum_mag  = sum_new[VALUE_WIDTH-1] ? (~sum_new + 1'b1) : sum_new;
  assign cnt_new  = (sample_count == '1) ? sample_count : (sample_count + 1'b1);
  assign hit      = {1'b0, sample_word.timestamp} > next_deadline;
  assign skip     = sample_word.cmd && !path_present;

  // restoring divide, one quotient bit a step
  assign rem_sh   = {div_rem, div_quot[VALUE_WIDTH-1]};
  assign rem_ge   = rem_sh >= {1'b0, rep_count};
  assign rem_diff = rem_sh - {1'b0, rep_count};
  assign avg      = rep_neg ? (~div_quot + 1'b1) : div_quot;

  assign status.hit      = hit;
  assign status.skip     = skip;
  assign status.mode     = report_mode;
  assign status.path     = path_present;
  assign status.div_last = div_cnt == DIV_CNT_W'(VALUE_WIDTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      report_mode    <= MODE_ALL;
      interval_ticks <= '0;
      path_present   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:     report_mode    <= mode_t'(cfg_data[1:0]);
        REG_INTERVAL: interval_ticks <= cfg_data[INTERVAL_W-1:0];
        REG_PATH:     path_present   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_value <= '0;
      running_min   <= MIN_INIT;
      running_max   <= MAX_INIT;
      running_sum   <= '0;
      sample_count  <= '0;
      next_deadline <= '0;
    end else if (cmd.accept && !skip) begin
      current_value <= new_v;
      if (hit) begin
        running_min   <= MIN_INIT;
        running_max   <= MAX_INIT;
        running_sum   <= '0;
        sample_count  <= '0;
        next_deadline <= {1'b0, sample_word.timestamp} + DEADLINE_W'(interval_ticks);
      end else begin
        running_min  <= min_new;
        running_max  <= max_new;
        running_sum  <= sum_new;
        sample_count <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !skip && hit) begin
      rep_min   <= min_new;
      rep_max   <= max_new;
      rep_neg   <= sum_new[VALUE_WIDTH-1];
      rep_count <= cnt_new;
      div_quot  <= sum_mag;
      div_rem   <= '0;
      div_cnt   <= '0;
    end else if (cmd.div_step) begin
      div_quot <= {div_quot[VALUE_WIDTH-2:0], rem_ge};
      div_rem  <= rem_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      div_cnt  <= div_cnt + 1'b1;
    end
  end

  always_comb begin
    case (cmd.kind)
      KIND_MIN: out_v = rep_min;
      KIND_MAX: out_v = rep_max;
      KIND_AVG: out_v = avg;
      default:  out_v = current_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_word.kind         <= cmd.kind;
      result_word.result_value <= OUT_W'($signed(out_v));
      result_word.last         <= cmd.kind == KIND_CUR;
    end
  end

endmodule

/* hdl/imma_ctrl.sv */
module imma_ctrl import imma_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t     state;
  state_t     state_next;
  logic [3:0] pend;
  logic [3:0] accept_mask;
  logic       slot_free;
  kind_t      pick;

  // results this word causes, one bit per kind
  always_comb begin
    accept_mask = '0;
    accept_mask[KIND_CUR] = 1'b1;
    if (!status.skip && status.hit && status.path) begin
      case (status.mode)
        MODE_ALL: begin
          accept_mask[KIND_MIN] = 1'b1;
          accept_mask[KIND_MAX] = 1'b1;
          accept_mask[KIND_AVG] = 1'b1;
        end
        MODE_MIN: accept_mask[KIND_MIN] = 1'b1;
        MODE_MAX: accept_mask[KIND_MAX] = 1'b1;
        default:  accept_mask[KIND_AVG] = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (pend[KIND_MIN]) begin
      pick = KIND_MIN;
    end else if (pend[KIND_MAX]) begin
      pick = KIND_MAX;
    end else if (pend[KIND_AVG]) begin
      pick = KIND_AVG;
    end else begin
      pick = KIND_CUR;
    end
  end

  assign slot_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = accept_mask[KIND_AVG] ? ST_DIV : ST_SEND;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (slot_free && pick == KIND_CUR) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = state == ST_IDLE;
    cmd.accept   = (state == ST_IDLE) && sample_valid;
    cmd.div_step = state == ST_DIV;
    cmd.load     = (state == ST_SEND) && slot_free;
    cmd.kind     = pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        pend <= accept_mask;
      end else if (cmd.load) begin
        pend[pick] <= 1'b0;
      end
      // hold the word until taken
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/interval_min_max_avg_aggregator.sv */
// Flow: a word is taken in the idle state; when an average is reported the shift-subtract
//   divider runs first, then the send state registers the results one by one as the slot frees.
// Each word yields N results (1 to 4); the one-word-at-a-time controller takes no new word
//   until the last result of the current word has been loaded.
// Reset: synchronous rst clears statistics, deadline and output valid, and restores
//   report_mode 0, interval_ticks 0, path_present 1.
module interval_min_max_avg_aggregator import imma_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_t               sample_word,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  imma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  imma_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .sample_word (sample_word),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .result_word (result_word)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import imma_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;
  localparam int DRAIN_CYCLES = VALUE_WIDTH_DEF + 16;
  localparam int HOLD_CYCLES = 400;

  class window_stats;
    logic signed [63:0] cur;
    logic signed [63:0] lo_val;
    logic signed [63:0] hi_val;
    logic signed [63:0] sum_val;
    logic [31:0] count;
    logic [63:0] deadline;
    mode_t mode;
    logic [31:0] span;
    logic path_on;
    result_t pending_results[$];
    int fails;

    function new();
      cur = '0;
      deadline = '0;
      mode = MODE_ALL;
      span = '0;
      path_on = 1'b1;
      fails = 0;
      clear_window();
    endfunction

    function void clear_window();
      lo_val = VMAX;
      hi_val = VMIN;
      sum_val = '0;
      count = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE: mode = mode_t'(data[1:0]);
        REG_INTERVAL: span = data;
        REG_PATH: path_on = data[0];
        default: ;
      endcase
    endfunction

    function void expect_word(kind_t k, logic signed [63:0] v, logic l);
      result_t e;
      e.kind = k;
      e.result_value = v;
      e.last = l;
      pending_results.push_back(e);
    endfunction

    function void take_sample(sample_t w);
      logic signed [63:0] v;
      logic signed [63:0] lo;
      logic signed [63:0] hi;
      logic signed [63:0] avg;
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] now;
      // increments are dropped while no path is set up
      if (w.cmd && !path_on) begin
        expect_word(KIND_CUR, cur, 1'b1);
        return;
      end
      now = {1'b0, w.timestamp};
      v = w.cmd ? cur + w.sample_value : w.sample_value;
      if (count != '1) count++;
      cur = v;
      if (v < lo_val) lo_val = v;
      if (v > hi_val) hi_val = v;
      sum_val = sum_val + v;
      if (now > deadline) begin
        // divide the magnitude so the quotient rounds toward zero
        mag = sum_val[63] ? -sum_val : sum_val;
        quo = mag / {32'd0, count};
        avg = sum_val[63] ? -quo : quo;
        lo = lo_val;
        hi = hi_val;
        clear_window();
        deadline = now + {32'd0, span};
        if (path_on) begin
          case (mode)
            MODE_ALL: begin
              expect_word(KIND_MIN, lo, 1'b0);
              expect_word(KIND_MAX, hi, 1'b0);
              expect_word(KIND_AVG, avg, 1'b0);
            end
            MODE_MIN: expect_word(KIND_MIN, lo, 1'b0);
            MODE_MAX: expect_word(KIND_MAX, hi, 1'b0);
            default: expect_word(KIND_AVG, avg, 1'b0);
          endcase
        end
      end
      expect_word(KIND_CUR, cur, 1'b1);
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d value %0d last %0d",
               r.kind, r.result_value, r.last);
        fails++;
        return;
      end
      e = pending_results.pop_front();
      if (r.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, r.kind);
        fails++;
      end
      if (r.result_value !== e.result_value) begin
        $error("result_value: expected %0d, got %0d", e.result_value, r.result_value);
        fails++;
      end
      if (r.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, r.last);
        fails++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_ready;
  sample_t sample_word;
  logic result_valid;
  logic result_ready;
  result_t result_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  window_stats stats = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  logic [TS_W-1:0] stamp = '0;

  interval_min_max_avg_aggregator uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_word(sample_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word(result_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) stats.check_result(result_word);
  end

  function automatic logic signed [63:0] pick_value();
    logic signed [63:0] v;
    case ($urandom_range(0, 9))
      0: v = VMAX;
      1: v = VMIN;
      2, 3: v = {$urandom, $urandom};
      4, 5: v = 64'(int'($urandom));
      default: begin
        v = 64'($urandom_range(0, 200));
        v = v - 64'sd100;
      end
    endcase
    return v;
  endfunction

  function automatic void advance_stamp();
    case ($urandom_range(0, 39))
      0: if (stamp > 63'd5) stamp = stamp - 63'd5;
      1, 2: stamp = stamp + 63'({$urandom_range(0, 3), $urandom});
      default: stamp = stamp + 63'($urandom_range(0, 6));
    endcase
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic send_word(logic c, logic signed [63:0] v, logic [TS_W-1:0] ts);
    sample_t w;
    w.cmd = c;
    w.sample_value = v;
    w.timestamp = ts;
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_word <= w;
    do @(posedge clk); while (!sample_ready);
    stats.take_sample(w);
    @(negedge clk);
  endtask

  // write only once the block has drained
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    sample_valid <= 1'b0;
    while (stats.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    stats.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(mode_t m, logic [31:0] ivl, logic p, int n, int s_pct, int r_pct,
                           bit hold);
    set_reg(REG_MODE, ($urandom & ~32'd3) | 32'(m));
    set_reg(REG_INTERVAL, ivl);
    set_reg(REG_PATH, ($urandom & ~32'd1) | 32'(p));
    idle_pct = s_pct;
    stall_pct = r_pct;
    if (hold) hold_req = 1'b1;
    repeat (n) begin
      advance_stamp();
      send_word(1'($urandom_range(0, 1)), pick_value(), stamp);
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, wraparound of value and delta, truncation of a negative mean
    send_word(1'b0, 64'sd0, 63'd0);
    send_word(1'b0, VMAX, 63'd1);
    send_word(1'b0, VMIN, 63'd1);
    send_word(1'b1, -64'sd1, 63'd1);
    send_word(1'b1, 64'sd1, 63'd2);
    send_word(1'b1, VMIN, 63'd2);
    send_word(1'b0, -64'sd7, 63'd3);
    send_word(1'b0, 64'sd2, 63'd3);
    send_word(1'b0, 64'sd0, 63'd3);
    send_word(1'b0, 64'sd0, 63'd4);

    // no path: increments dropped, samples counted silently
    set_reg(REG_PATH, 32'd0);
    set_reg(REG_SPARE, $urandom);
    send_word(1'b1, 64'sd5, 63'd5);
    send_word(1'b0, 64'sd9, 63'd6);
    send_word(1'b1, VMAX, 63'd7);

    set_reg(REG_PATH, 32'd1);
    set_reg(REG_MODE, 32'(MODE_MIN));
    send_word(1'b1, 64'sd3, 63'd8);
    set_reg(REG_MODE, 32'(MODE_MAX));
    send_word(1'b0, -64'sd3, 63'd9);
    set_reg(REG_MODE, 32'(MODE_AVG));
    send_word(1'b0, -64'sd1, 63'd9);
    send_word(1'b0, -64'sd2, 63'd10);
    stamp = 63'd10;

    run_phase(MODE_ALL, 32'd0, 1'b1, 60, 0, 0, 1'b1);
    run_phase(MODE_MIN, 32'd5, 1'b1, 60, 52, 0, 1'b0);
    run_phase(MODE_MAX, 32'd20, 1'b1, 60, 0, 52, 1'b0);
    run_phase(MODE_AVG, 32'd3, 1'b1, 60, 29, 29, 1'b0);
    run_phase(MODE_ALL, 32'hFFFF_FFFF, 1'b1, 60, 0, 0, 1'b0);
    run_phase(MODE_ALL, 32'd1, 1'b0, 60, 52, 0, 1'b0);
    run_phase(mode_t'($urandom_range(0, 3)), $urandom_range(0, 40), 1'b1, 60, 29, 29, 1'b0);
    run_phase(MODE_ALL, 32'd2, 1'b1, 48, 0, 52, 1'b0);

    // top timestamp bits last: the deadline never comes back down
    set_reg(REG_MODE, 32'(MODE_ALL));
    set_reg(REG_INTERVAL, $urandom);
    idle_pct = 29;
    stall_pct = 29;
    repeat (11) begin
      stamp = 63'({$urandom, $urandom});
      send_word(1'($urandom_range(0, 1)), pick_value(), stamp);
    end
    send_word(1'b0, pick_value(), '1);

    sample_valid <= 1'b0;
    while (stats.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stats.fails == 0 && stats.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
